@@ hdl/preemptive_priority_scheduler_macros.svh @@
// Assertion helpers shared by the scheduler modules.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

@@ hdl/pps_pkg.sv @@
package pps_pkg;

    localparam int TASK_SLOTS_DEF      = 16;
    localparam int BURSTS_PER_TASK_DEF = 16;
    localparam int TICK_LIMIT_DEF      = 1000;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int TICK_W  = 10;
    localparam int PRIO_W  = 8;
    localparam int TOTAL_W = 5;
    localparam int BNUM_W  = 4;
    localparam int LEN_W   = 10;
    localparam int WAIT_W  = 10;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_DEFINE = 2'd0,
        CMD_BURST  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_STATS  = 2'd3
    } cmd_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic op;
        logic arr;
        logic sel;
        logic cpu_rd;
        logic cpu_wr;
        logic io_rd;
        logic io_wr;
        logic wait_step;
        logic resp;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic fin;
        logic cpu_held;
        logic io_held;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/pps_ram.sv @@
module pps_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pps_ctrl.sv @@
`include "preemptive_priority_scheduler_macros.svh"

module pps_ctrl #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pps_pkg::sts_t                 sts,
    output pps_pkg::ctl_t                 ctl,
    output logic [$clog2(TASK_SLOTS)-1:0] sweep_idx
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CMD    = 10'b0000000010,
        S_ARR    = 10'b0000000100,
        S_SEL    = 10'b0000001000,
        S_CPU_RD = 10'b0000010000,
        S_CPU_WR = 10'b0000100000,
        S_IO_RD  = 10'b0001000000,
        S_IO_WR  = 10'b0010000000,
        S_WAIT   = 10'b0100000000,
        S_RESP   = 10'b1000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                idx_next = '0;
                if (sts.is_tick && !sts.fin)
                begin
                    state_next = S_ARR;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_ARR:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:    state_next = S_CPU_RD;
            S_CPU_RD: state_next = sts.cpu_held ? S_CPU_WR : S_IO_RD;
            S_CPU_WR: state_next = S_IO_RD;
            S_IO_RD:  state_next = sts.io_held ? S_IO_WR : S_WAIT;
            S_IO_WR:  state_next = S_WAIT;
            S_WAIT:   state_next = S_RESP;
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign sweep_idx     = idx_reg;
    assign ctl.start     = (state_reg == S_IDLE) && in_valid;
    assign ctl.op        = (state_reg == S_CMD);
    assign ctl.arr       = (state_reg == S_ARR);
    assign ctl.sel       = (state_reg == S_SEL);
    assign ctl.cpu_rd    = (state_reg == S_CPU_RD);
    assign ctl.cpu_wr    = (state_reg == S_CPU_WR);
    assign ctl.io_rd     = (state_reg == S_IO_RD);
    assign ctl.io_wr     = (state_reg == S_IO_WR);
    assign ctl.wait_step = (state_reg == S_WAIT);
    assign ctl.resp      = (state_reg == S_RESP) && sts.out_free;

    `PPS_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && !in_stall, state_reg == S_CMD)
    `PPS_ASSERT_NEXT(a_sweep_ends, clk, rst_n, (state_reg == S_ARR) && (idx_reg == LAST_IDX), state_reg == S_SEL)
    `PPS_ASSERT_IMP(a_resp_when_free, clk, rst_n, ctl.resp, sts.out_free)

endmodule

@@ hdl/pps_dp.sv @@
`include "preemptive_priority_scheduler_macros.svh"

module pps_dp #(
    parameter int TASK_SLOTS      = 16,
    parameter int BURSTS_PER_TASK = 16,
    parameter int TICK_LIMIT      = 1000
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pps_pkg::ctl_t                  ctl,
    output pps_pkg::sts_t                  sts,
    input  logic [$clog2(TASK_SLOTS)-1:0]  sweep_idx,
    input  logic [pps_pkg::CMD_W-1:0]      command,
    input  logic [pps_pkg::SLOT_W-1:0]     slot,
    input  logic [pps_pkg::TICK_W-1:0]     arrival_tick,
    input  logic [pps_pkg::PRIO_W-1:0]     task_priority,
    input  logic [pps_pkg::TOTAL_W-1:0]    burst_total,
    input  logic [pps_pkg::BNUM_W-1:0]     burst_number,
    input  logic [pps_pkg::LEN_W-1:0]      burst_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           cpu_busy,
    output logic [pps_pkg::SLOT_W-1:0]     cpu_task,
    output logic                           io_busy,
    output logic [pps_pkg::SLOT_W-1:0]     io_task,
    output logic                           all_done,
    output logic [pps_pkg::TICK_W-1:0]     tick_now,
    output logic                           task_finished,
    output logic [pps_pkg::TICK_W-1:0]     task_end_tick,
    output logic [pps_pkg::WAIT_W-1:0]     task_waiting
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int POS_W = $clog2(BURSTS_PER_TASK + 1);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int DEPTH = TASK_SLOTS * BURSTS_PER_TASK;
    localparam int AW    = $clog2(DEPTH);
    localparam int SEQ_W = $clog2((TICK_LIMIT + 1) * (TASK_SLOTS + 3) + 1);

    function automatic logic [AW-1:0] burst_addr(input logic [IDX_W-1:0] idx, input int pos);
        return AW'(int'(idx) * BURSTS_PER_TASK + pos);
    endfunction

    // Latched input item.
    cmd_t               cmd_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [TICK_W-1:0]  arr_in_reg;
    logic [PRIO_W-1:0]  prio_in_reg;
    logic [TOTAL_W-1:0] total_in_reg;
    logic [BNUM_W-1:0]  bnum_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [TICK_W-1:0]  tick_at_reg;

    // Per-slot state.
    logic [TASK_SLOTS-1:0] valid_reg;
    logic [TASK_SLOTS-1:0] done_reg;
    logic [TASK_SLOTS-1:0] ready_reg;
    logic [TASK_SLOTS-1:0] fresh_reg;
    logic [POS_W-1:0]      pos_reg    [TASK_SLOTS];
    logic [TICK_W-1:0]     end_reg    [TASK_SLOTS];
    logic [WAIT_W-1:0]     wait_reg   [TASK_SLOTS];
    logic [TICK_W-1:0]     arrival_reg[TASK_SLOTS];
    logic [PRIO_W-1:0]     prio_reg   [TASK_SLOTS];
    logic [POS_W-1:0]      total_reg  [TASK_SLOTS];
    logic [LEN_W-1:0]      rem_reg    [TASK_SLOTS];
    logic [SEQ_W-1:0]      seq_reg    [TASK_SLOTS];
    logic [IDX_W-1:0]      fifo_reg   [TASK_SLOTS];

    logic [IDX_W-1:0]  fifo_head_reg, fifo_tail_reg;
    logic [CNT_W-1:0]  fifo_cnt_reg;
    logic              cpu_held_reg, io_held_reg;
    logic [IDX_W-1:0]  cpu_idx_reg, io_idx_reg;
    logic [PRIO_W-1:0] cpu_prio_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [CNT_W-1:0]  valid_cnt_reg, done_cnt_reg;
    logic [SEQ_W-1:0]  seq_ctr_reg;
    logic              best_valid_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [SEQ_W-1:0]  best_seq_reg;

    // Result being assembled, then the output register.
    logic              res_cpu_busy_reg, res_io_busy_reg, res_fin_task_reg;
    logic [SLOT_W-1:0] res_cpu_task_reg, res_io_task_reg;
    logic [TICK_W-1:0] res_end_reg;
    logic [WAIT_W-1:0] res_wait_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  slot_idx, addr;
    logic              slot_ok, fin;
    logic              define_we, burst_we;
    logic [POS_W-1:0]  total_clamped;
    logic [LEN_W-1:0]  ram_rdata, ram_len, cur_len, dec_len;
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic [LEN_W-1:0]  ram_wdata;
    logic [POS_W-1:0]  pos_inc;
    logic              exec, burst_end, is_last;
    logic              hit, preempt_arr, cand_ok, cand_better;
    logic [SEQ_W-1:0]  cand_seq;
    logic              io_ret, preempt_io, sel_cpu, sel_io;
    logic [IDX_W-1:0]  cpu_idx_sel, io_idx_sel;
    logic              out_free;

    assign slot_ok  = int'(slot_reg) < TASK_SLOTS;
    assign slot_idx = IDX_W'(slot_reg);
    assign fin      = (int'(tick_reg) >= TICK_LIMIT) || (done_cnt_reg >= valid_cnt_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (ctl.arr)
        begin
            addr = sweep_idx;
        end
        else if (ctl.cpu_rd || ctl.cpu_wr)
        begin
            addr = cpu_idx_reg;
        end
        else if (ctl.io_rd || ctl.io_wr)
        begin
            addr = io_idx_reg;
        end
        else
        begin
            addr = slot_idx;
        end
    end

    assign define_we = ctl.op && (cmd_reg == CMD_DEFINE) && (tick_reg == '0) && slot_ok;
    assign burst_we  = ctl.op && (cmd_reg == CMD_BURST) && (tick_reg == '0) && slot_ok
                       && (int'(bnum_reg) < BURSTS_PER_TASK);

    always_comb
    begin
        if (total_in_reg == '0)
        begin
            total_clamped = POS_W'(1);
        end
        else if (int'(total_in_reg) > BURSTS_PER_TASK)
        begin
            total_clamped = POS_W'(BURSTS_PER_TASK);
        end
        else
        begin
            total_clamped = POS_W'(total_in_reg);
        end
    end

    assign ram_waddr = burst_addr(slot_idx, int'(bnum_reg));
    assign ram_wdata = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign ram_raddr = burst_addr(addr, int'(pos_reg[addr]));

    pps_ram #(
        .WIDTH (LEN_W),
        .DEPTH (DEPTH)
    ) u_burst_ram (
        .clk   (clk),
        .we    (burst_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A fresh slot takes its length from the burst memory instead of the remaining count.
    assign exec      = ctl.cpu_wr || ctl.io_wr;
    assign ram_len   = (ram_rdata == '0) ? LEN_W'(1) : ram_rdata;
    assign cur_len   = fresh_reg[addr] ? ram_len : rem_reg[addr];
    assign dec_len   = cur_len - LEN_W'(1);
    assign burst_end = (dec_len == '0);
    assign pos_inc   = pos_reg[addr] + POS_W'(1);
    assign is_last   = pos_inc >= total_reg[addr];

    assign hit         = valid_reg[addr] && (arrival_reg[addr] == tick_reg);
    assign preempt_arr = ctl.arr && hit && cpu_held_reg && (prio_reg[addr] > cpu_prio_reg);
    assign cand_ok     = ready_reg[addr] || hit;
    assign cand_seq    = hit ? seq_ctr_reg : seq_reg[addr];
    assign cand_better = !best_valid_reg || (prio_reg[addr] > best_prio_reg)
                         || ((prio_reg[addr] == best_prio_reg) && (cand_seq < best_seq_reg));

    assign io_ret     = ctl.io_wr && burst_end && !is_last;
    assign preempt_io = io_ret && cpu_held_reg && (prio_reg[addr] > cpu_prio_reg);

    assign sel_cpu     = ctl.sel && !cpu_held_reg && best_valid_reg;
    assign sel_io      = ctl.sel && !io_held_reg && (fifo_cnt_reg != '0);
    assign cpu_idx_sel = sel_cpu ? best_idx_reg : cpu_idx_reg;
    assign io_idx_sel  = sel_io ? fifo_reg[fifo_head_reg] : io_idx_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg      <= cmd_t'(command);
            slot_reg     <= slot;
            arr_in_reg   <= arrival_tick;
            prio_in_reg  <= task_priority;
            total_in_reg <= burst_total;
            bnum_reg     <= burst_number;
            len_reg      <= burst_length;
            tick_at_reg  <= tick_reg;
        end
        if (define_we)
        begin
            arrival_reg[addr] <= arr_in_reg;
            prio_reg[addr]    <= prio_in_reg;
            total_reg[addr]   <= total_clamped;
        end
        if (ctl.arr && hit)
        begin
            fresh_reg[addr] <= 1'b1;
            seq_reg[addr]   <= seq_ctr_reg;
        end
        if (preempt_arr || preempt_io)
        begin
            seq_reg[cpu_idx_reg] <= seq_ctr_reg + SEQ_W'(1);
        end
        if (exec)
        begin
            if (burst_end)
            begin
                fresh_reg[addr] <= !is_last;
            end
            else
            begin
                rem_reg[addr]   <= dec_len;
                fresh_reg[addr] <= 1'b0;
            end
        end
        if (io_ret)
        begin
            seq_reg[addr] <= seq_ctr_reg;
        end
        if (ctl.cpu_wr && burst_end && !is_last)
        begin
            fifo_reg[fifo_tail_reg] <= addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= '0;
            ready_reg <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                pos_reg[i]  <= '0;
                end_reg[i]  <= '0;
                wait_reg[i] <= '0;
            end
        end
        else
        begin
            if (define_we)
            begin
                valid_reg[addr] <= 1'b1;
                done_reg[addr]  <= 1'b0;
                pos_reg[addr]   <= '0;
                end_reg[addr]   <= '0;
                wait_reg[addr]  <= '0;
            end
            if (ctl.arr && hit)
            begin
                pos_reg[addr]   <= '0;
                ready_reg[addr] <= 1'b1;
            end
            if (preempt_arr || preempt_io)
            begin
                ready_reg[cpu_idx_reg] <= 1'b1;
            end
            if (sel_cpu)
            begin
                ready_reg[best_idx_reg] <= 1'b0;
            end
            if (exec && burst_end)
            begin
                pos_reg[addr] <= pos_inc;
                if (is_last)
                begin
                    done_reg[addr] <= 1'b1;
                    end_reg[addr]  <= tick_reg + TICK_W'(1);
                end
            end
            if (io_ret)
            begin
                ready_reg[addr] <= 1'b1;
            end
            if (ctl.wait_step)
            begin
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (ready_reg[i] && (wait_reg[i] != WAIT_MAX))
                    begin
                        wait_reg[i] <= wait_reg[i] + WAIT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_head_reg    <= '0;
            fifo_tail_reg    <= '0;
            fifo_cnt_reg     <= '0;
            cpu_held_reg     <= 1'b0;
            io_held_reg      <= 1'b0;
            cpu_idx_reg      <= '0;
            io_idx_reg       <= '0;
            cpu_prio_reg     <= '0;
            tick_reg         <= '0;
            valid_cnt_reg    <= '0;
            done_cnt_reg     <= '0;
            seq_ctr_reg      <= '0;
            best_valid_reg   <= 1'b0;
            best_idx_reg     <= '0;
            best_prio_reg    <= '0;
            best_seq_reg     <= '0;
            res_cpu_busy_reg <= 1'b0;
            res_io_busy_reg  <= 1'b0;
            res_fin_task_reg <= 1'b0;
            res_cpu_task_reg <= '0;
            res_io_task_reg  <= '0;
            res_end_reg      <= '0;
            res_wait_reg     <= '0;
            out_valid_reg    <= 1'b0;
            cpu_busy         <= 1'b0;
            cpu_task         <= '0;
            io_busy          <= 1'b0;
            io_task          <= '0;
            all_done         <= 1'b0;
            tick_now         <= '0;
            task_finished    <= 1'b0;
            task_end_tick    <= '0;
            task_waiting     <= '0;
        end
        else
        begin
            if (ctl.start)
            begin
                best_valid_reg   <= 1'b0;
                res_cpu_busy_reg <= 1'b0;
                res_io_busy_reg  <= 1'b0;
                res_fin_task_reg <= 1'b0;
                res_cpu_task_reg <= '0;
                res_io_task_reg  <= '0;
                res_end_reg      <= '0;
                res_wait_reg     <= '0;
            end
            if (define_we && !valid_reg[addr])
            begin
                valid_cnt_reg <= valid_cnt_reg + CNT_W'(1);
            end
            if (ctl.op && (cmd_reg == CMD_STATS) && slot_ok)
            begin
                res_fin_task_reg <= done_reg[addr];
                res_end_reg      <= end_reg[addr];
                res_wait_reg     <= wait_reg[addr];
            end

            // Arrival sweep: insertions, preemption of the CPU task and a running search for the queue head.
            if (ctl.arr)
            begin
                if (hit)
                begin
                    seq_ctr_reg <= seq_ctr_reg + (preempt_arr ? SEQ_W'(2) : SEQ_W'(1));
                end
                if (preempt_arr)
                begin
                    cpu_held_reg <= 1'b0;
                end
                if (cand_ok && cand_better)
                begin
                    best_valid_reg <= 1'b1;
                    best_idx_reg   <= addr;
                    best_prio_reg  <= prio_reg[addr];
                    best_seq_reg   <= cand_seq;
                end
            end

            if (ctl.sel)
            begin
                if (sel_cpu)
                begin
                    cpu_held_reg <= 1'b1;
                    cpu_idx_reg  <= best_idx_reg;
                    cpu_prio_reg <= best_prio_reg;
                end
                if (sel_io)
                begin
                    io_held_reg   <= 1'b1;
                    io_idx_reg    <= io_idx_sel;
                    fifo_head_reg <= (int'(fifo_head_reg) == TASK_SLOTS - 1) ? '0
                                     : fifo_head_reg + IDX_W'(1);
                    fifo_cnt_reg  <= fifo_cnt_reg - CNT_W'(1);
                end
                res_cpu_busy_reg <= cpu_held_reg || sel_cpu;
                res_cpu_task_reg <= (cpu_held_reg || sel_cpu) ? SLOT_W'(cpu_idx_sel) : '0;
                res_io_busy_reg  <= io_held_reg || sel_io;
                res_io_task_reg  <= (io_held_reg || sel_io) ? SLOT_W'(io_idx_sel) : '0;
            end

            if (exec && burst_end && is_last)
            begin
                done_cnt_reg <= done_cnt_reg + CNT_W'(1);
            end
            if (ctl.cpu_wr && burst_end)
            begin
                cpu_held_reg <= 1'b0;
                if (!is_last)
                begin
                    fifo_tail_reg <= (int'(fifo_tail_reg) == TASK_SLOTS - 1) ? '0
                                     : fifo_tail_reg + IDX_W'(1);
                    fifo_cnt_reg  <= fifo_cnt_reg + CNT_W'(1);
                end
            end
            if (ctl.io_wr && burst_end)
            begin
                io_held_reg <= 1'b0;
            end
            if (io_ret)
            begin
                seq_ctr_reg <= seq_ctr_reg + (preempt_io ? SEQ_W'(2) : SEQ_W'(1));
            end
            if (preempt_io)
            begin
                cpu_held_reg <= 1'b0;
            end

            if (ctl.wait_step)
            begin
                tick_reg <= tick_reg + TICK_W'(1);
            end

            if (ctl.resp)
            begin
                out_valid_reg <= 1'b1;
                cpu_busy      <= res_cpu_busy_reg;
                cpu_task      <= res_cpu_task_reg;
                io_busy       <= res_io_busy_reg;
                io_task       <= res_io_task_reg;
                all_done      <= fin;
                tick_now      <= tick_at_reg;
                task_finished <= res_fin_task_reg;
                task_end_tick <= res_end_reg;
                task_waiting  <= res_wait_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.is_tick  = (cmd_reg == CMD_TICK);
    assign sts.fin      = fin;
    assign sts.cpu_held = cpu_held_reg;
    assign sts.io_held  = io_held_reg;
    assign sts.out_free = out_free;

    `PPS_ASSERT_IMP(a_cpu_io_distinct, clk, rst_n, cpu_held_reg && io_held_reg, cpu_idx_reg != io_idx_reg)
    `PPS_ASSERT_IMP(a_done_bounded, clk, rst_n, 1'b1, done_cnt_reg <= valid_cnt_reg)
    `PPS_ASSERT_NEXT(a_resp_shows, clk, rst_n, ctl.resp, out_valid_reg)

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
// Define, burst-write and statistics items, and a tick after the run has ended, pass through the
// command and response states only. Any other tick sweeps the slots one per cycle, then serves
// the CPU and then the I/O task before the tick count advances.
// One item is in work at a time; the next is accepted in the same cycle that the result appears
// in the output register, while it waits there.
// Asynchronous active-low reset empties both queues, marks all slots undefined and clears the tick count.
module preemptive_priority_scheduler #(
    parameter int TASK_SLOTS      = pps_pkg::TASK_SLOTS_DEF,
    parameter int BURSTS_PER_TASK = pps_pkg::BURSTS_PER_TASK_DEF,
    parameter int TICK_LIMIT      = pps_pkg::TICK_LIMIT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pps_pkg::CMD_W-1:0]   command,
    input  logic [pps_pkg::SLOT_W-1:0]  slot,
    input  logic [pps_pkg::TICK_W-1:0]  arrival_tick,
    input  logic [pps_pkg::PRIO_W-1:0]  task_priority,
    input  logic [pps_pkg::TOTAL_W-1:0] burst_total,
    input  logic [pps_pkg::BNUM_W-1:0]  burst_number,
    input  logic [pps_pkg::LEN_W-1:0]   burst_length,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        cpu_busy,
    output logic [pps_pkg::SLOT_W-1:0]  cpu_task,
    output logic                        io_busy,
    output logic [pps_pkg::SLOT_W-1:0]  io_task,
    output logic                        all_done,
    output logic [pps_pkg::TICK_W-1:0]  tick_now,
    output logic                        task_finished,
    output logic [pps_pkg::TICK_W-1:0]  task_end_tick,
    output logic [pps_pkg::WAIT_W-1:0]  task_waiting
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);

    ctl_t             ctl;
    sts_t             sts;
    logic [IDX_W-1:0] sweep_idx;

    pps_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sts       (sts),
        .ctl       (ctl),
        .sweep_idx (sweep_idx)
    );

    pps_dp #(
        .TASK_SLOTS      (TASK_SLOTS),
        .BURSTS_PER_TASK (BURSTS_PER_TASK),
        .TICK_LIMIT      (TICK_LIMIT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .sweep_idx     (sweep_idx),
        .command       (command),
        .slot          (slot),
        .arrival_tick  (arrival_tick),
        .task_priority (task_priority),
        .burst_total   (burst_total),
        .burst_number  (burst_number),
        .burst_length  (burst_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cpu_busy      (cpu_busy),
        .cpu_task      (cpu_task),
        .io_busy       (io_busy),
        .io_task       (io_task),
        .all_done      (all_done),
        .tick_now      (tick_now),
        .task_finished (task_finished),
        .task_end_tick (task_end_tick),
        .task_waiting  (task_waiting)
    );

endmodule
